// ===== rtl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg: shared types for the bounded list engine
// command and response beats, status codes, controller to datapath link
// ----------------------------------------------------------------------------
package ble_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK    = 3'd0,
    CMD_PUSH_FRONT   = 3'd1,
    CMD_POP_BACK     = 3'd2,
    CMD_POP_FRONT    = 3'd3,
    CMD_FIND         = 3'd4,
    CMD_INSERT_AFTER = 3'd5,
    CMD_ERASE_AFTER  = 3'd6,
    CMD_CLEAR        = 3'd7
  } ble_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } ble_status_e;

  localparam int unsigned LenW = 5;

  typedef struct packed {
    ble_cmd_e           cmd;
    logic signed [31:0] value;
  } ble_req_t;

  typedef struct packed {
    ble_status_e     status;
    logic            found;
    logic [LenW-1:0] length;
  } ble_rsp_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH_BACK,
    DP_PUSH_FRONT,
    DP_DROP_BACK,
    DP_DROP_FRONT,
    DP_READ_HEAD,
    DP_COPY_PREV,
    DP_INSERT_HEAD,
    DP_COPY_NEXT,
    DP_WRITE_SOLE,
    DP_CLEAR,
    DP_SCAN
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic            single;
    logic            scan_done;
    logic            found;
    logic [LenW-1:0] length;
  } dp_stat_t;

endpackage

// ===== rtl/ble_stream_if.sv =====
// ----------------------------------------------------------------------------
// ble_stream_if: valid/ready channel
// one beat moves when valid and ready are both high at a rising edge
// ----------------------------------------------------------------------------
interface ble_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ble_datapath.sv =====
// ----------------------------------------------------------------------------
// ble_datapath: list storage and pointers
// circular buffer with head pointer and count, one write and one read port
// ----------------------------------------------------------------------------
module ble_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_i,
  input  ble_pkg::dp_cmd_t   dp_cmd_i,
  output ble_pkg::dp_stat_t  dp_stat_o
);
  import ble_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic signed [31:0] mem [DEPTH];

  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      scan_cnt_q, scan_cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic               found_q, found_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] rd_q;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [31:0] wr_data;
  logic [CW+4:0]      cnt_ext;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == LAST) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST : a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    scan_cnt_d = scan_cnt_q;
    rd_vld_d   = 1'b0;
    found_d    = found_q;
    key_d      = key_q;
    wr_en      = 1'b0;
    wr_addr    = head_q;
    wr_data    = key_q;
    rd_en      = 1'b0;
    rd_addr    = head_q;

    // compare the word read in the previous cycle
    if (rd_vld_q && (rd_q == key_q)) begin
      found_d = 1'b1;
    end

    unique case (dp_cmd_i.op)
      DP_NOP: begin
      end
      DP_PUSH_BACK: begin
        wr_en   = 1'b1;
        wr_addr = addr_add(head_q, count_q[AW-1:0]);
        count_d = count_q + CW'(1);
      end
      DP_PUSH_FRONT: begin
        wr_en   = 1'b1;
        wr_addr = addr_dec(head_q);
        head_d  = addr_dec(head_q);
        count_d = count_q + CW'(1);
      end
      DP_DROP_BACK: begin
        count_d = count_q - CW'(1);
      end
      DP_DROP_FRONT: begin
        head_d  = addr_inc(head_q);
        count_d = count_q - CW'(1);
      end
      DP_READ_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
      end
      DP_COPY_PREV: begin
        // first element moves one slot toward the front
        wr_en   = 1'b1;
        wr_addr = addr_dec(head_q);
        wr_data = rd_q;
      end
      DP_INSERT_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = head_q;
        head_d  = addr_dec(head_q);
        count_d = count_q + CW'(1);
      end
      DP_COPY_NEXT: begin
        // first element overwrites the second, which is dropped
        wr_en   = 1'b1;
        wr_addr = addr_inc(head_q);
        wr_data = rd_q;
        head_d  = addr_inc(head_q);
        count_d = count_q - CW'(1);
      end
      DP_WRITE_SOLE: begin
        wr_en   = 1'b1;
        wr_addr = head_q;
        count_d = CW'(1);
      end
      DP_CLEAR: begin
        count_d = '0;
      end
      DP_SCAN: begin
        if (scan_cnt_q != count_q) begin
          rd_en      = 1'b1;
          rd_addr    = ptr_q;
          ptr_d      = addr_inc(ptr_q);
          scan_cnt_d = scan_cnt_q + CW'(1);
          rd_vld_d   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (dp_cmd_i.load) begin
      key_d      = value_i;
      ptr_d      = head_q;
      scan_cnt_d = '0;
      found_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      head_q     <= head_d;
      count_q    <= count_d;
      scan_cnt_q <= scan_cnt_d;
      rd_vld_q   <= rd_vld_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    key_q <= key_d;
  end

  assign cnt_ext = (CW+5)'(count_q);

  assign dp_stat_o.full      = (count_q == DEPTH_C);
  assign dp_stat_o.empty     = (count_q == '0);
  assign dp_stat_o.single    = (count_q == CW'(1));
  assign dp_stat_o.scan_done = (scan_cnt_q == count_q) && !rd_vld_q;
  assign dp_stat_o.found     = found_q;
  assign dp_stat_o.length    = cnt_ext[LenW-1:0];

endmodule

// ===== rtl/ble_ctrl.sv =====
// ----------------------------------------------------------------------------
// ble_ctrl: command sequencer
// decodes one command, steps the datapath, holds the response register
// ----------------------------------------------------------------------------
module ble_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ble_pkg::ble_cmd_e in_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ble_pkg::ble_rsp_t out_rsp_o,
  output ble_pkg::dp_cmd_t  dp_cmd_o,
  input  ble_pkg::dp_stat_t dp_stat_i
);
  import ble_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS_PREV,
    S_INS_HEAD,
    S_ERS_COPY,
    S_FIND,
    S_RESP
  } state_e;

  state_e      state_q, state_d;
  ble_cmd_e    cmd_q;
  ble_status_e status_q, status_d;
  logic        out_valid_q;
  ble_rsp_t    rsp_q;
  logic        in_acc;
  logic        rsp_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rsp_load   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    dp_cmd_o.load = in_acc;
    dp_cmd_o.op   = DP_NOP;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        state_d  = S_RESP;
        unique case (cmd_q)
          CMD_PUSH_BACK: begin
            if (dp_stat_i.full) status_d = ST_FULL;
            else dp_cmd_o.op = DP_PUSH_BACK;
          end
          CMD_PUSH_FRONT: begin
            if (dp_stat_i.full) status_d = ST_FULL;
            else dp_cmd_o.op = DP_PUSH_FRONT;
          end
          CMD_POP_BACK: begin
            if (dp_stat_i.empty) status_d = ST_EMPTY;
            else dp_cmd_o.op = DP_DROP_BACK;
          end
          CMD_POP_FRONT: begin
            if (dp_stat_i.empty) status_d = ST_EMPTY;
            else dp_cmd_o.op = DP_DROP_FRONT;
          end
          CMD_FIND: begin
            dp_cmd_o.op = DP_SCAN;
            state_d     = S_FIND;
          end
          CMD_INSERT_AFTER: begin
            if (dp_stat_i.full) begin
              status_d = ST_FULL;
            end else if (dp_stat_i.empty) begin
              // empty list: value becomes the sole element
              dp_cmd_o.op = DP_WRITE_SOLE;
            end else begin
              dp_cmd_o.op = DP_READ_HEAD;
              state_d     = S_INS_PREV;
            end
          end
          CMD_ERASE_AFTER: begin
            if (dp_stat_i.empty || dp_stat_i.single) begin
              status_d = ST_EMPTY;
            end else begin
              dp_cmd_o.op = DP_READ_HEAD;
              state_d     = S_ERS_COPY;
            end
          end
          CMD_CLEAR: begin
            dp_cmd_o.op = DP_CLEAR;
          end
          default: begin
          end
        endcase
      end
      S_INS_PREV: begin
        dp_cmd_o.op = DP_COPY_PREV;
        state_d     = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        dp_cmd_o.op = DP_INSERT_HEAD;
        state_d     = S_RESP;
      end
      S_ERS_COPY: begin
        dp_cmd_o.op = DP_COPY_NEXT;
        state_d     = S_RESP;
      end
      S_FIND: begin
        dp_cmd_o.op = DP_SCAN;
        if (dp_stat_i.scan_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_cmd_i;
    end
    if (rsp_load) begin
      rsp_q.status <= status_q;
      rsp_q.found  <= dp_stat_i.found;
      rsp_q.length <= dp_stat_i.length;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== rtl/bounded_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_list_engine: ordered list of up to DEPTH signed 32-bit values
// one command beat in, one response beat out
// ----------------------------------------------------------------------------
// usage
//   in_i  : command beat (cmd, value); accepted when valid and ready are high
//   out_o : response beat (status, found, length); length is the count mod 32
//   commands are taken one at a time; in_i.ready is high while the sequencer
//   is idle, even if the previous response is still waiting on out_o
// datapath steps of each command, in order
//   push, pop, clear, failed insert or erase : update or status check only
//   erase after first                        : head read, copy
//   insert after first                       : head read, copy, write
//   find over the held entries               : one memory read a cycle
//   the response turns valid in the same cycle that input ready returns
//   the single-port-read storage memory sets the find and insert steps
// reset
//   the list is empty at once, no clearing pass; storage contents are left
//   as they are and are only read after being written
// stall
//   a response held by out_o.ready keeps the sequencer in its response state
// ----------------------------------------------------------------------------
module bounded_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ble_stream_if.sink          in_i,
  ble_stream_if.source        out_o
);
  import ble_pkg::*;

  // controller to datapath link
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ble_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.data.cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_rsp_o   (out_o.data),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  // circular buffer: head pointer plus count, so front pushes and pops
  // and the after-first edits move at most one word
  ble_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .value_i   (in_i.data.value),
    .dp_cmd_i  (dp_cmd),
    .dp_stat_o (dp_stat)
  );

endmodule

// ===== rtl/ble_checker.sv =====
// ----------------------------------------------------------------------------
// ble_checker: port-level checks for the bounded list engine
// watches command and response beats, bound to the top level
// ----------------------------------------------------------------------------
module ble_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input ble_pkg::ble_rsp_t out_rsp_i
);
  import ble_pkg::*;

  logic [1:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // commands accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rsp_i))
    else $error("response changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 2'd0)
    else $error("response without a pending command");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rsp_i.found |-> out_rsp_i.status == ST_OK)
    else $error("found set on a failed command");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rsp_i.status == ST_FULL |-> out_rsp_i.length == LenW'(DEPTH))
    else $error("full status with list not at capacity");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rsp_i.status == ST_EMPTY |-> out_rsp_i.length <= LenW'(1))
    else $error("nothing-to-remove status with more than one entry");

endmodule

bind bounded_list_engine ble_checker #(
  .DEPTH (DEPTH)
) u_ble_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rsp_i   (out_o.data)
);

// ===== test/bounded_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_list_engine_tb: self-checking bench for the bounded list engine
// a mirror of the list predicts status, found and length for every command
// beat; directed corner cases come first, then random grow, shrink and mixed
// runs with bursty command traffic and a response side that stalls
// ----------------------------------------------------------------------------
module bounded_list_engine_tb;
  import ble_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned RAND_CMDS  = 800;
  localparam int unsigned LONG_HOLD  = 400;    // cycles the response side holds off
  localparam int unsigned END_SETTLE = 40;     // a find over a full list plus margin
  localparam int unsigned CYCLE_CAP  = 250000; // far above the slowest legal run

  // flavor of one random run of commands
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_e;

  // --------------------------------------------------------------------------
  // list mirror: holds the expected list contents and the responses still due
  // --------------------------------------------------------------------------
  class list_mirror;
    logic signed [31:0] slots[DEPTH];
    int unsigned        held;
    ble_rsp_t           due_rsp[$];
    int unsigned        errors;
    int unsigned        n_cmds, n_checked, n_full, n_nothing, n_hits;

    function new();
      held   = 0;
      errors = 0;
      n_cmds = 0; n_checked = 0; n_full = 0; n_nothing = 0; n_hits = 0;
    endfunction

    // update the mirror and return the response this command must produce
    function ble_rsp_t apply_command(ble_req_t req);
      ble_rsp_t rsp;
      int i;
      rsp.status = ST_OK;
      rsp.found  = 1'b0;
      case (req.cmd)
        CMD_PUSH_BACK: begin
          if (held >= DEPTH) rsp.status = ST_FULL;
          else begin
            slots[held] = req.value;
            held++;
          end
        end
        CMD_PUSH_FRONT: begin
          if (held >= DEPTH) rsp.status = ST_FULL;
          else begin
            for (i = held; i > 0; i--) slots[i] = slots[i-1];
            slots[0] = req.value;
            held++;
          end
        end
        CMD_POP_BACK: begin
          if (held == 0) rsp.status = ST_EMPTY;
          else held--;
        end
        CMD_POP_FRONT: begin
          if (held == 0) rsp.status = ST_EMPTY;
          else begin
            for (i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
          end
        end
        CMD_FIND: begin
          for (i = 0; i < held; i++)
            if (slots[i] == req.value) rsp.found = 1'b1;
        end
        CMD_INSERT_AFTER: begin
          if (held >= DEPTH) rsp.status = ST_FULL;
          else if (held == 0) begin
            // empty list: the value becomes the only entry
            slots[0] = req.value;
            held     = 1;
          end else begin
            for (i = held; i > 1; i--) slots[i] = slots[i-1];
            slots[1] = req.value;
            held++;
          end
        end
        CMD_ERASE_AFTER: begin
          // needs an entry behind the head
          if (held < 2) rsp.status = ST_EMPTY;
          else begin
            for (i = 1; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
          end
        end
        default: held = 0;
      endcase
      rsp.length = held[LenW-1:0];
      return rsp;
    endfunction

    function void note_command(ble_req_t req);
      ble_rsp_t rsp;
      rsp = apply_command(req);
      n_cmds++;
      if (rsp.status == ST_FULL)  n_full++;
      if (rsp.status == ST_EMPTY) n_nothing++;
      if (rsp.found)              n_hits++;
      due_rsp.insert(due_rsp.size(), rsp);
    endfunction

    function void check_response(ble_rsp_t got);
      ble_rsp_t want;
      if (due_rsp.size() == 0) begin
        $error("response beat with no command outstanding");
        errors++;
        return;
      end
      want = due_rsp[0];
      due_rsp.delete(0);
      n_checked++;
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found mismatch: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length mismatch: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ble_stream_if #(.T(ble_req_t)) cmd_if ();
  ble_stream_if #(.T(ble_rsp_t)) rsp_if ();

  bounded_list_engine #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  list_mirror  mirror = new();
  bit          long_hold_req;   // set by the command side, cleared by the response side
  int unsigned burst_left;      // command beats left before the next gap
  int unsigned cycle_count;

  // 10 time unit clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // command side
  // --------------------------------------------------------------------------

  // offer one command beat and hold it until the block takes it; bursts of
  // random length are separated by short random gaps that may be empty
  task automatic send_cmd(ble_cmd_e op, logic signed [31:0] val);
    ble_req_t req;
    int unsigned gap;
    req.cmd   = op;
    req.value = val;
    if (burst_left == 0) begin
      gap = $urandom_range(4);
      // long bursts now and then give stretches with no idling
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= req;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
    mirror.note_command(req);
    burst_left--;
  endtask

  // stop offering and wait for every outstanding response
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (mirror.due_rsp.size() != 0) @(posedge clk_i);
  endtask

  // often values already in the list so finds hit, plus extremes and noise
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40 && mirror.held != 0) return mirror.slots[$urandom_range(mirror.held - 1)];
    if (r < 55) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic ble_cmd_e pick_cmd(mix_e mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW: begin
        if (r < 35) return CMD_PUSH_BACK;
        if (r < 60) return CMD_PUSH_FRONT;
        if (r < 80) return CMD_INSERT_AFTER;
        if (r < 92) return CMD_FIND;
      end
      MIX_SHRINK: begin
        if (r < 25) return CMD_POP_BACK;
        if (r < 50) return CMD_POP_FRONT;
        if (r < 75) return CMD_ERASE_AFTER;
        if (r < 90) return CMD_FIND;
      end
      default: begin
        // clear kept rare so the list still gets deep
        if (r < 3) return CMD_CLEAR;
        if (r < 90) return ble_cmd_e'($urandom_range(int'(CMD_ERASE_AFTER)));
      end
    endcase
    return ble_cmd_e'($urandom_range(int'(CMD_CLEAR)));
  endfunction

  // --------------------------------------------------------------------------
  // response side: its own stall pattern, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : rsp_stall
    int unsigned pattern, span;
    logic        rdy;
    rdy = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        // commands keep coming while the response is stuck, so the
        // sequencer parks and drops its input ready
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        pattern = $urandom_range(3);
        span    = $urandom_range(5, 60);
        repeat (span) begin
          case (pattern)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(3) != 0);
            2: rdy = ~rdy;
            default: rdy = $urandom_range(1);
          endcase
          rsp_if.ready <= rdy;
          @(posedge clk_i);
        end
      end
    end
  end

  // response checking
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) mirror.check_response(rsp_if.data);
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("cycle limit of %0d reached, %0d responses still due",
           CYCLE_CAP, mirror.due_rsp.size());
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned        sent, span, i;
    mix_e               mix;
    int unsigned        r;
    logic signed [31:0] fill_val;

    rst_ni        = 1'b0;
    long_hold_req = 1'b0;
    burst_left    = 0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    rsp_if.ready <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list corners
    send_cmd(CMD_FIND,         32'h0000_0000);  // find on empty: ok, not found
    send_cmd(CMD_POP_BACK,     32'h0000_0000);  // nothing to remove
    send_cmd(CMD_POP_FRONT,    32'hffff_ffff);
    send_cmd(CMD_ERASE_AFTER,  32'h0000_0000);
    send_cmd(CMD_INSERT_AFTER, 32'h7fff_ffff);  // insert on empty: sole entry
    send_cmd(CMD_ERASE_AFTER,  32'h0000_0000);  // single entry, nothing behind head
    send_cmd(CMD_FIND,         32'h7fff_ffff);
    send_cmd(CMD_POP_BACK,     32'h0000_0000);  // pop of the only entry empties it

    // fill to the brim through all three insert paths
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0: fill_val = 32'h8000_0000;
        1: fill_val = 32'h7fff_ffff;
        2: fill_val = 32'hffff_ffff;
        3: fill_val = 32'h0000_0000;
        default: fill_val = $urandom;
      endcase
      case (i % 3)
        0: send_cmd(CMD_PUSH_BACK, fill_val);
        1: send_cmd(CMD_PUSH_FRONT, fill_val);
        default: send_cmd(CMD_INSERT_AFTER, fill_val);
      endcase
    end
    send_cmd(CMD_PUSH_BACK,    32'h1234_5678);  // full: rejected
    send_cmd(CMD_PUSH_FRONT,   32'h1234_5678);
    send_cmd(CMD_INSERT_AFTER, 32'h1234_5678);
    send_cmd(CMD_FIND,         32'h8000_0000);
    send_cmd(CMD_POP_FRONT,    32'h0000_0000);
    send_cmd(CMD_ERASE_AFTER,  32'h0000_0000);
    send_cmd(CMD_CLEAR,        32'h0000_0000);

    // sender pause with nothing in flight
    wait_drained();

    // random runs of grow, shrink and mixed traffic
    sent = 0;
    while (sent < RAND_CMDS) begin
      r    = $urandom_range(99);
      mix  = (r < 40) ? MIX_GROW : (r < 65) ? MIX_SHRINK : MIX_ANY;
      span = $urandom_range(10, 40);
      repeat (span) begin
        send_cmd(pick_cmd(mix), pick_value());
        sent++;
        if (sent == RAND_CMDS / 2) long_hold_req = 1'b1;
        if (sent % 200 == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (END_SETTLE) @(posedge clk_i);

    if (mirror.due_rsp.size() != 0) begin
      $error("%0d responses never arrived", mirror.due_rsp.size());
      mirror.errors++;
    end

    $display("covered %0d command beats, %0d response beats checked in %0d cycles",
             mirror.n_cmds, mirror.n_checked, cycle_count);
    $display("inserts refused on a full list %0d, removals with nothing there %0d, find hits %0d",
             mirror.n_full, mirror.n_nothing, mirror.n_hits);
    if (mirror.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== bounded_list_engine.f =====
rtl/ble_pkg.sv
rtl/ble_stream_if.sv
rtl/ble_datapath.sv
rtl/ble_ctrl.sv
rtl/bounded_list_engine.sv
rtl/ble_checker.sv
test/bounded_list_engine_tb.sv
